// ===== hdl/rctm_pkg.sv =====
package rctm_pkg;

    localparam int SCREEN_HEIGHT_DEF  = 512;
    localparam int TEXTURE_WIDTH_DEF  = 64;
    localparam int TEXTURE_HEIGHT_DEF = 64;

    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int OUT_ROW_W   = 9;
    localparam int DIST_W      = 24;
    localparam int POS_W       = 24;
    localparam int DIR_W       = 18;
    localparam int COLOR_W     = 24;
    localparam int SPAN_W      = 26;
    localparam int TEX_POS_W   = 40;
    localparam int TEX_COORD_W = 6;
    localparam int FRAC_W      = 16;
    localparam int MUL_ACC_W   = 56;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int S_TDATA_W   = 128;
    localparam int M_TDATA_W   = 64;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CEILING = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR   = 1'b1;

    typedef enum logic
    {
        KIND_SETUP = 1'b0,
        KIND_ROW   = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        REGION_CEILING = 2'd0,
        REGION_FLOOR   = 2'd1,
        REGION_WALL    = 2'd2
    } region_t;

    typedef enum logic [1:0]
    {
        TEX_NORTH = 2'd0,
        TEX_SOUTH = 2'd1,
        TEX_WEST  = 2'd2,
        TEX_EAST  = 2'd3
    } texture_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [COL_W-1:0]  column;
        logic [DIST_W-1:0] distance;
        logic [FRAC_W-1:0] pos_frac;
        logic [FRAC_W-1:0] prod_frac;
        logic              mirror;
        texture_t          texture;
    } item_t;

    typedef struct packed
    {
        logic [COL_W-1:0]       column;
        logic [OUT_ROW_W-1:0]   row;
        region_t                region;
        logic [COLOR_W-1:0]     color;
        texture_t               texture;
        logic [TEX_COORD_W-1:0] tex_col;
        logic [TEX_COORD_W-1:0] tex_row;
        logic                   last;
    } pixel_t;

    function automatic int wh_width(input int sh);
        return $clog2(sh) + 33;
    endfunction

    function automatic int div_width(input int sh, input int th);
        int a;
        int b;
        a = $clog2(sh) + 33;
        b = $clog2(th) + 33;
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hdl/rctm_front.sv =====
module rctm_front
    import rctm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 item_valid,
    input  logic                 item_ready,
    output item_t                item
);

    localparam int COL_LSB  = 0;
    localparam int DIST_LSB = COL_LSB + COL_W;
    localparam int SIDE_BIT = DIST_LSB + DIST_W;
    localparam int PX_LSB   = SIDE_BIT + 1;
    localparam int PY_LSB   = PX_LSB + POS_W;
    localparam int DX_LSB   = PY_LSB + POS_W;
    localparam int DY_LSB   = DX_LSB + DIR_W;
    localparam int SIN_BIT  = DY_LSB + DIR_W;
    localparam int COS_BIT  = SIN_BIT + 1;

    logic                          valid_reg;
    item_t                         item_reg;
    item_t                         item_next;
    logic [DIST_W-1:0]             dist_raw;
    logic [DIST_W-1:0]             dist_fix;
    logic                          side;
    logic [POS_W-1:0]              pos_sel;
    logic signed [DIR_W-1:0]       dir_x;
    logic signed [DIR_W-1:0]       dir_y;
    logic signed [DIR_W-1:0]       dir_sel;
    logic signed [DIST_W:0]        dist_s;
    logic signed [DIST_W+DIR_W:0]  prod;

    assign s_axis_tready = !valid_reg || item_ready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb
    begin
        dist_raw = s_axis_tdata[DIST_LSB +: DIST_W];
        dist_fix = (dist_raw == '0) ? DIST_W'(1) : dist_raw;
        side     = s_axis_tdata[SIDE_BIT];
        dir_x    = s_axis_tdata[DX_LSB +: DIR_W];
        dir_y    = s_axis_tdata[DY_LSB +: DIR_W];
        dir_sel  = side ? dir_x : dir_y;
        pos_sel  = side ? s_axis_tdata[PX_LSB +: POS_W] : s_axis_tdata[PY_LSB +: POS_W];
        dist_s   = $signed({1'b0, dist_fix});
        prod     = dist_s * dir_sel;

        item_next.kind      = kind_t'(s_axis_tuser);
        item_next.column    = s_axis_tdata[COL_LSB +: COL_W];
        item_next.distance  = dist_fix;
        item_next.pos_frac  = pos_sel[FRAC_W-1:0];
        item_next.prod_frac = prod[FRAC_W +: FRAC_W];
        item_next.mirror    = side ? !dir_y[DIR_W-1] : dir_x[DIR_W-1];
        if (side)
        begin
            item_next.texture = s_axis_tdata[SIN_BIT] ? TEX_NORTH : TEX_SOUTH;
        end
        else
        begin
            item_next.texture = s_axis_tdata[COS_BIT] ? TEX_WEST : TEX_EAST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hdl/rctm_queue.sv =====
module rctm_queue
    import rctm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != (Q_PTR_W+1)'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/rctm_divider.sv =====
module rctm_divider
    import rctm_pkg::*;
#(
    parameter int W = div_width(SCREEN_HEIGHT_DEF, TEXTURE_HEIGHT_DEF)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     den_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
        else if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
    end

endmodule

// ===== hdl/rctm_back.sv =====
module rctm_back
    import rctm_pkg::*;
#(
    parameter int SCREEN_HEIGHT  = SCREEN_HEIGHT_DEF,
    parameter int TEXTURE_WIDTH  = TEXTURE_WIDTH_DEF,
    parameter int TEXTURE_HEIGHT = TEXTURE_HEIGHT_DEF,
    localparam int DIV_W = div_width(SCREEN_HEIGHT, TEXTURE_HEIGHT)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   div_start,
    output logic [DIV_W-1:0]       div_dividend,
    output logic [DIV_W-1:0]       div_divisor,
    input  logic                   div_done,
    input  logic [DIV_W-1:0]       div_quotient,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pixel_t                 out_pixel
);

    localparam int WH_W   = wh_width(SCREEN_HEIGHT);
    localparam int OFF_W  = WH_W - 1;
    localparam int TW_W   = $clog2(TEXTURE_WIDTH + 1);
    localparam int MCNT_W = $clog2(OFF_W + 1);
    localparam int TROW_W = TEX_POS_W - 16;

    localparam logic [SPAN_W-1:0] MID        = SPAN_W'(SCREEN_HEIGHT * 32768);
    localparam logic [SPAN_W-1:0] BOTTOM_MAX = SPAN_W'((SCREEN_HEIGHT - 1) * 65536);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [DIV_W-1:0]  WH_DIVIDEND   = DIV_W'(SCREEN_HEIGHT) << 32;
    localparam logic [DIV_W-1:0]  STEP_DIVIDEND = DIV_W'(TEXTURE_HEIGHT) << 32;
    localparam logic [TW_W-1:0]   TW_MAX  = TW_W'(TEXTURE_WIDTH - 1);
    localparam logic [TW_W-1:0]   TW_MUL  = TW_W'(TEXTURE_WIDTH);
    localparam logic [TROW_W-1:0] TH_MASK = TROW_W'(TEXTURE_HEIGHT - 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV_WH,
        ST_DIV_STEP,
        ST_MUL
    } state_t;

    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    pixel_t                 pixel_reg, pixel_next;
    logic [COLOR_W-1:0]     ceil_reg, ceil_next;
    logic [COLOR_W-1:0]     floor_reg, floor_next;
    logic [COL_W-1:0]       cur_column_reg, cur_column_next;
    logic [ROW_W-1:0]       row_count_reg, row_count_next;
    logic                   column_done_reg, column_done_next;
    logic [SPAN_W-1:0]      span_top_reg, span_top_next;
    logic [SPAN_W-1:0]      span_bottom_reg, span_bottom_next;
    logic [TEX_POS_W-1:0]   texel_pos_reg, texel_pos_next;
    logic [TEX_POS_W-1:0]   texel_step_reg, texel_step_next;
    logic [TEX_COORD_W-1:0] hit_tex_col_reg, hit_tex_col_next;
    texture_t               hit_texture_reg, hit_texture_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic                   mirror_reg, mirror_next;
    logic [WH_W-1:0]        wh_reg, wh_next;
    logic [OFF_W-1:0]       mplier_reg, mplier_next;
    logic [MUL_ACC_W-1:0]   mcand_reg, mcand_next;
    logic [MUL_ACC_W-1:0]   acc_reg, acc_next;
    logic [MCNT_W-1:0]      mcnt_reg, mcnt_next;

    logic                   pop;
    logic [SPAN_W-1:0]      rq;
    logic [OFF_W-1:0]       half;
    logic [OFF_W-1:0]       mid_w;
    logic [OFF_W-1:0]       bottom_sum;
    logic                   half_ge;
    logic [OFF_W-1:0]       off;
    logic [SPAN_W-1:0]      span_top_calc;
    logic [SPAN_W-1:0]      span_bottom_calc;
    logic [FRAC_W+TW_W-1:0] tc_prod;
    logic [TW_W-1:0]        tc;
    logic [TW_W-1:0]        tc_mirrored;
    logic [TROW_W-1:0]      tex_row_full;

    assign item_ready = pop;
    assign out_valid  = out_valid_reg;
    assign out_pixel  = pixel_reg;

    always_comb
    begin
        pop = item_valid && (state_reg == ST_IDLE)
              && ((item.kind == KIND_SETUP) || !out_valid_reg || out_ready);

        rq = SPAN_W'({row_count_reg, 16'h0000});

        half       = wh_reg[WH_W-1:1];
        mid_w      = OFF_W'(MID);
        half_ge    = (half >= mid_w);
        bottom_sum = mid_w + half;
        off        = half_ge ? (half - mid_w) : '0;
        span_top_calc    = half_ge ? '0 : SPAN_W'(mid_w - half);
        span_bottom_calc = (bottom_sum > OFF_W'(BOTTOM_MAX)) ? BOTTOM_MAX
                                                             : SPAN_W'(bottom_sum);

        tc_prod     = (FRAC_W+TW_W)'(frac_reg) * (FRAC_W+TW_W)'(TW_MUL);
        tc          = tc_prod[FRAC_W +: TW_W];
        tc_mirrored = mirror_reg ? (TW_MAX - tc) : tc;

        tex_row_full = texel_pos_reg[16 +: TROW_W] & TH_MASK;
    end

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_next       = pixel_reg;
        ceil_next        = ceil_reg;
        floor_next       = floor_reg;
        cur_column_next  = cur_column_reg;
        row_count_next   = row_count_reg;
        column_done_next = column_done_reg;
        span_top_next    = span_top_reg;
        span_bottom_next = span_bottom_reg;
        texel_pos_next   = texel_pos_reg;
        texel_step_next  = texel_step_reg;
        hit_tex_col_next = hit_tex_col_reg;
        hit_texture_next = hit_texture_reg;
        frac_next        = frac_reg;
        mirror_next      = mirror_reg;
        wh_next          = wh_reg;
        mplier_next      = mplier_reg;
        mcand_next       = mcand_reg;
        acc_next         = acc_reg;
        mcnt_next        = mcnt_reg;
        div_start        = 1'b0;
        div_dividend     = WH_DIVIDEND;
        div_divisor      = DIV_W'(item.distance);

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CEILING: ceil_next  = cfg_data;
                CFG_FLOOR:   floor_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && (item.kind == KIND_SETUP))
                begin
                    cur_column_next  = item.column;
                    row_count_next   = '0;
                    column_done_next = 1'b0;
                    hit_texture_next = item.texture;
                    frac_next        = item.pos_frac + item.prod_frac;
                    mirror_next      = item.mirror;
                    div_start        = 1'b1;
                    state_next       = ST_DIV_WH;
                end
                else if (pop && !column_done_reg)
                begin
                    out_valid_next     = 1'b1;
                    pixel_next.column  = cur_column_reg;
                    pixel_next.row     = row_count_reg[OUT_ROW_W-1:0];
                    pixel_next.color   = '0;
                    pixel_next.texture = TEX_NORTH;
                    pixel_next.tex_col = '0;
                    pixel_next.tex_row = '0;
                    priority if (rq < span_top_reg)
                    begin
                        pixel_next.region = REGION_CEILING;
                        pixel_next.color  = ceil_reg;
                    end
                    else if (rq > span_bottom_reg)
                    begin
                        pixel_next.region = REGION_FLOOR;
                        pixel_next.color  = floor_reg;
                    end
                    else
                    begin
                        pixel_next.region  = REGION_WALL;
                        pixel_next.texture = hit_texture_reg;
                        pixel_next.tex_col = hit_tex_col_reg;
                        pixel_next.tex_row = TEX_COORD_W'(tex_row_full);
                        texel_pos_next     = texel_pos_reg + texel_step_reg;
                    end
                    if (row_count_reg >= LAST_ROW)
                    begin
                        pixel_next.last  = 1'b1;
                        column_done_next = 1'b1;
                        row_count_next   = '0;
                    end
                    else
                    begin
                        pixel_next.last = 1'b0;
                        row_count_next  = row_count_reg + 1'b1;
                    end
                end
            end

            ST_DIV_WH:
            begin
                if (div_done)
                begin
                    wh_next          = div_quotient[WH_W-1:0];
                    hit_tex_col_next = TEX_COORD_W'(tc_mirrored);
                    div_start        = 1'b1;
                    div_dividend     = STEP_DIVIDEND;
                    div_divisor      = DIV_W'(div_quotient[WH_W-1:0]);
                    state_next       = ST_DIV_STEP;
                end
            end

            ST_DIV_STEP:
            begin
                if (div_done)
                begin
                    texel_step_next  = TEX_POS_W'(div_quotient);
                    span_top_next    = span_top_calc;
                    span_bottom_next = span_bottom_calc;
                    mplier_next      = off;
                    mcand_next       = MUL_ACC_W'(div_quotient);
                    acc_next         = '0;
                    mcnt_next        = MCNT_W'(OFF_W);
                    state_next       = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (mcnt_reg == '0)
                begin
                    texel_pos_next = acc_reg[16 +: TEX_POS_W];
                    state_next     = ST_IDLE;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                    mcnt_next   = mcnt_reg - 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            ceil_reg        <= '0;
            floor_reg       <= '0;
            cur_column_reg  <= '0;
            row_count_reg   <= '0;
            column_done_reg <= 1'b1;
            mcnt_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            ceil_reg        <= ceil_next;
            floor_reg       <= floor_next;
            cur_column_reg  <= cur_column_next;
            row_count_reg   <= row_count_next;
            column_done_reg <= column_done_next;
            mcnt_reg        <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg       <= pixel_next;
        span_top_reg    <= span_top_next;
        span_bottom_reg <= span_bottom_next;
        texel_pos_reg   <= texel_pos_next;
        texel_step_reg  <= texel_step_next;
        hit_tex_col_reg <= hit_tex_col_next;
        hit_texture_reg <= hit_texture_next;
        frac_reg        <= frac_next;
        mirror_reg      <= mirror_next;
        wh_reg          <= wh_next;
        mplier_reg      <= mplier_next;
        mcand_reg       <= mcand_next;
        acc_reg         <= acc_next;
    end

endmodule

// ===== hdl/raycast_column_texel_mapper.sv =====
// Textured wall column mapper for a grid raycaster. A setup word (tuser 0) carries one
// ray hit; the block derives the wall span, texel step, start position, texel column and
// texture for that column. Each row word (tuser 1) then yields one pixel, top to bottom:
// ceiling, wall or floor, with tlast on the bottom row. Row words stream at one per clock
// while the back end is idle and the output is not stalled. A setup word occupies the back
// end while two DIV_W-bit divisions run one quotient bit per cycle on a shared divider, then
// a (WH_W-1)-bit shift-add multiplier forms the start position one bit per cycle, where
// WH_W = clog2(SCREEN_HEIGHT)+33 and DIV_W = max(WH_W, clog2(TEXTURE_HEIGHT)+33).
// A two-word queue lets the input side take words while a setup word is in the back end.
// Write the colour registers only while no pixel is pending.
module raycast_column_texel_mapper
    import rctm_pkg::*;
#(
    parameter int SCREEN_HEIGHT  = SCREEN_HEIGHT_DEF,
    parameter int TEXTURE_WIDTH  = TEXTURE_WIDTH_DEF,
    parameter int TEXTURE_HEIGHT = TEXTURE_HEIGHT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // column[9:0] distance[33:10] side[34] pos_x[58:35] pos_y[82:59]
    // dir_x[100:83] dir_y[118:101] sin_nonneg[119] cos_nonneg[120]
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // kind[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_column[9:0] out_row[18:10] color[42:19] texture[44:43]
    // tex_col[50:45] tex_row[56:51]
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // region[1:0]
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int DIV_W = div_width(SCREEN_HEIGHT, TEXTURE_HEIGHT);

    logic             front_valid;
    logic             front_ready;
    item_t            front_item;
    logic             q_valid;
    logic             q_ready;
    item_t            q_item;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quotient;
    pixel_t           pixel;

    rctm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    rctm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    rctm_divider #(.W(DIV_W)) u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    rctm_back #(
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .TEXTURE_WIDTH  (TEXTURE_WIDTH),
        .TEXTURE_HEIGHT (TEXTURE_HEIGHT)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (q_valid),
        .item_ready   (q_ready),
        .item         (q_item),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_pixel    (pixel)
    );

    assign m_axis_tdata = M_TDATA_W'({pixel.tex_row, pixel.tex_col, pixel.texture,
                                      pixel.color, pixel.row, pixel.column});
    assign m_axis_tuser = pixel.region;
    assign m_axis_tlast = pixel.last;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import rctm_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int PRINT_LIMIT   = 100;

    localparam logic [63:0] MID_Q16    = 64'(SCREEN_HEIGHT_DEF) << 15;
    localparam logic [63:0] BOTTOM_MAX = 64'(SCREEN_HEIGHT_DEF - 1) << 16;

    typedef struct
    {
        kind_t             kind;
        logic [COL_W-1:0]  column;
        logic [DIST_W-1:0] distance;
        logic              side;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic              sin_nonneg;
        logic              cos_nonneg;
    } ray_word_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = CFG_CEILING;
    logic [COLOR_W-1:0]     cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    logic [COLOR_W-1:0] ceiling_rgb  = '0;
    logic [COLOR_W-1:0] floor_rgb    = '0;
    logic [COL_W-1:0]   col_sel      = '0;
    logic [ROW_W-1:0]   row_idx      = '0;
    logic [63:0]        top_edge     = '0;
    logic [63:0]        bottom_edge  = '0;
    logic [TEX_POS_W-1:0] tex_acc    = '0;
    logic [TEX_POS_W-1:0] tex_inc    = '0;
    logic [TEX_COORD_W-1:0] col_texel = '0;
    texture_t           col_tex      = TEX_NORTH;
    bit                 column_open  = 1'b0;

    pixel_t pending_pixels[$];
    int     useful_words   = 0;
    int     mismatch_count = 0;
    int     idle_cycles    = 0;
    int     hold_left      = 0;
    bit     steady_flow    = 1'b0;

    raycast_column_texel_mapper dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int idle_span();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_word(input ray_word_t w);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[9:0]     = w.column;
        d[33:10]   = w.distance;
        d[34]      = w.side;
        d[58:35]   = w.pos_x;
        d[82:59]   = w.pos_y;
        d[100:83]  = w.dir_x;
        d[118:101] = w.dir_y;
        d[119]     = w.sin_nonneg;
        d[120]     = w.cos_nonneg;
        return d;
    endfunction

    function automatic ray_word_t make_hit(input logic [COL_W-1:0] column,
                                           input logic [DIST_W-1:0] distance,
                                           input logic side,
                                           input logic [POS_W-1:0] pos_x,
                                           input logic [POS_W-1:0] pos_y,
                                           input int dir_x,
                                           input int dir_y,
                                           input logic sin_nonneg,
                                           input logic cos_nonneg);
        ray_word_t w;
        w.kind       = KIND_SETUP;
        w.column     = column;
        w.distance   = distance;
        w.side       = side;
        w.pos_x      = pos_x;
        w.pos_y      = pos_y;
        w.dir_x      = DIR_W'(dir_x);
        w.dir_y      = DIR_W'(dir_y);
        w.sin_nonneg = sin_nonneg;
        w.cos_nonneg = cos_nonneg;
        return w;
    endfunction

    function automatic ray_word_t random_hit();
        ray_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        w.kind = KIND_SETUP;
        w.column = COL_W'($urandom);
        if (pick < 35)
            w.distance = DIST_W'($urandom_range(1, 65536));
        else if (pick < 70)
            w.distance = DIST_W'($urandom_range(65536, 1 << 20));
        else if (pick < 90)
            w.distance = DIST_W'($urandom);
        else
            w.distance = DIST_W'($urandom_range(0, 255));
        w.side       = 1'($urandom);
        w.pos_x      = POS_W'($urandom);
        w.pos_y      = POS_W'($urandom);
        w.dir_x      = DIR_W'($urandom);
        w.dir_y      = DIR_W'($urandom);
        w.sin_nonneg = 1'($urandom);
        w.cos_nonneg = 1'($urandom);
        return w;
    endfunction

    function automatic ray_word_t random_row();
        ray_word_t w;
        w = random_hit();
        w.kind = KIND_ROW;
        return w;
    endfunction

    function automatic void map_word(input ray_word_t w);
        logic [63:0] d;
        logic [63:0] wh;
        logic [63:0] half;
        logic [63:0] step;
        logic [63:0] off;
        logic [63:0] t;
        logic [63:0] rq;
        logic [FRAC_W-1:0] frac;
        logic signed [63:0] dir;
        logic signed [63:0] prod;
        logic [TEX_COORD_W-1:0] tc;
        pixel_t p;
        if (w.kind == KIND_SETUP)
        begin
            d = (w.distance == 0) ? 64'd1 : 64'(w.distance);
            wh = (64'(SCREEN_HEIGHT_DEF) << 32) / d;
            half = wh >> 1;
            top_edge = (half >= MID_Q16) ? 64'd0 : MID_Q16 - half;
            bottom_edge = (MID_Q16 + half > BOTTOM_MAX) ? BOTTOM_MAX : MID_Q16 + half;
            step = (wh == 0) ? 64'd0 : (64'(TEXTURE_HEIGHT_DEF) << 32) / wh;
            off = top_edge + half - MID_Q16;
            tex_acc = TEX_POS_W'((off * step) >> 16);
            tex_inc = TEX_POS_W'(step);
            if (w.side)
            begin
                dir = 64'(w.dir_x);
                t = 64'(w.pos_x) << 16;
            end
            else
            begin
                dir = 64'(w.dir_y);
                t = 64'(w.pos_y) << 16;
            end
            prod = $signed(d) * dir;
            t = t + prod;
            frac = t[31:16];
            tc = TEX_COORD_W'((64'(frac) * TEXTURE_WIDTH_DEF) >> 16);
            // mirror so texels read left to right from the viewer
            if ((w.side && !w.dir_y[DIR_W-1]) || (!w.side && w.dir_x[DIR_W-1]))
                tc = TEX_COORD_W'(TEXTURE_WIDTH_DEF - 1) - tc;
            col_texel = tc;
            if (w.side)
                col_tex = w.sin_nonneg ? TEX_NORTH : TEX_SOUTH;
            else
                col_tex = w.cos_nonneg ? TEX_WEST : TEX_EAST;
            col_sel = w.column;
            row_idx = '0;
            column_open = 1'b1;
            useful_words++;
        end
        else if (column_open)
        begin
            rq = 64'(row_idx) << 16;
            p.column  = col_sel;
            p.row     = row_idx[OUT_ROW_W-1:0];
            p.color   = '0;
            p.texture = TEX_NORTH;
            p.tex_col = '0;
            p.tex_row = '0;
            if (rq < top_edge)
            begin
                p.region = REGION_CEILING;
                p.color  = ceiling_rgb;
            end
            else if (rq > bottom_edge)
            begin
                p.region = REGION_FLOOR;
                p.color  = floor_rgb;
            end
            else
            begin
                p.region  = REGION_WALL;
                p.texture = col_tex;
                p.tex_col = col_texel;
                p.tex_row = TEX_COORD_W'(tex_acc[TEX_POS_W-1:16] & (TEXTURE_HEIGHT_DEF - 1));
                tex_acc   = tex_acc + tex_inc;
            end
            p.last = (row_idx >= SCREEN_HEIGHT_DEF - 1);
            if (p.last)
            begin
                column_open = 1'b0;
                row_idx = '0;
            end
            else
                row_idx = row_idx + 1'b1;
            pending_pixels.push_back(p);
            useful_words++;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want_v, input pixel_t want);
        if (got !== want_v)
            report_mismatch($sformatf("col %0d row %0d %s: got %0h want %0h",
                                      want.column, want.row, name, got, want_v));
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pending_pixels.size() == 0)
        begin
            report_mismatch($sformatf("pixel col %0d row %0d with none expected",
                                      m_axis_tdata[9:0], m_axis_tdata[18:10]));
            return;
        end
        want = pending_pixels.pop_front();
        check_field("column",  32'(m_axis_tdata[9:0]),   32'(want.column),  want);
        check_field("row",     32'(m_axis_tdata[18:10]), 32'(want.row),     want);
        check_field("region",  32'(m_axis_tuser),        32'(want.region),  want);
        check_field("color",   32'(m_axis_tdata[42:19]), 32'(want.color),   want);
        check_field("texture", 32'(m_axis_tdata[44:43]), 32'(want.texture), want);
        check_field("tex_col", 32'(m_axis_tdata[50:45]), 32'(want.tex_col), want);
        check_field("tex_row", 32'(m_axis_tdata[56:51]), 32'(want.tex_row), want);
        check_field("last",    32'(m_axis_tlast),        32'(want.last),    want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_pixel();
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!steady_flow && $urandom_range(0, 99) < 15)
            begin
                hold_left <= idle_span();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_word(input ray_word_t w);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) >= 55)
            gap = idle_span();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_word(w);
        s_axis_tuser  <= w.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        map_word(w);
    endtask

    // drop valid, let every pixel drain, then let queued setups finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] ceil_v,
                              input logic [COLOR_W-1:0] floor_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CEILING;
        cfg_data  <= ceil_v;
        @(posedge clk);
        cfg_index <= CFG_FLOOR;
        cfg_data  <= floor_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ceiling_rgb = ceil_v;
        floor_rgb   = floor_v;
    endtask

    task automatic test_orphan_rows();
        repeat (3) send_word(random_row());
    endtask

    task automatic test_directed_hits();
        wait_idle();
        set_colors(24'hFFFFFF, 24'h000000);
        send_word(make_hit(10'd0, 24'd0, 1'b0, 24'd0, 24'd0, -131072, 131071, 1'b0, 1'b0));
        repeat (2) send_word(random_row());
        send_word(make_hit(10'd1023, 24'd1, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 131071, 0,
                           1'b1, 1'b0));
        repeat (2) send_word(random_row());
        send_word(make_hit(10'd512, 24'hFFFFFF, 1'b1, 24'h012345, 24'h00ABCD, -131072, -1,
                           1'b0, 1'b1));
        repeat (2) send_word(random_row());
        send_word(make_hit(10'd300, 24'h010000, 1'b0, 24'h7FFFFF, 24'h800000, 65536, -65536,
                           1'b1, 1'b1));
        repeat (3) send_word(random_row());
        // restart mid-column
        send_word(make_hit(10'd301, 24'h008000, 1'b0, 24'h000001, 24'h123456, -1, 131071,
                           1'b0, 1'b1));
        repeat (3) send_word(random_row());
    endtask

    task automatic test_random_columns(input int n_words, input logic [COLOR_W-1:0] ceil_v,
                                       input logic [COLOR_W-1:0] floor_v, input bit steady,
                                       input bit full_first);
        int start;
        int nrows;
        int pick;
        bit first;
        wait_idle();
        set_colors(ceil_v, floor_v);
        steady_flow = steady;
        start = useful_words;
        first = full_first;
        while (useful_words - start < n_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && !first)
                send_word(random_row());
            else
            begin
                send_word(random_hit());
                pick = $urandom_range(0, 99);
                if (first || pick < 10)
                    nrows = SCREEN_HEIGHT_DEF + $urandom_range(0, 3);
                else if (pick < 60)
                    nrows = $urandom_range(1, 48);
                else if (pick < 85)
                    nrows = $urandom_range(49, SCREEN_HEIGHT_DEF - 1);
                else
                    nrows = 0;
                first = 1'b0;
                repeat (nrows) send_word(random_row());
            end
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_orphan_rows();
        test_directed_hits();
        test_random_columns(500, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1);
        test_random_columns(400, COLOR_W'($urandom), COLOR_W'($urandom), 1'b1, 1'b0);
        test_random_columns(450, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0);
        test_random_columns(450, COLOR_W'($urandom), COLOR_W'($urandom), 1'b0, 1'b0);
        wait_idle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
